// ===== rtl/sitd_pkg.sv =====
`timescale 1ns / 1ps

package sitd_pkg;

  localparam int VALUE_W   = 32;
  localparam int CHAR_W    = 8;
  localparam int DIGIT_W   = 4;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W     = NUM_DIGITS * DIGIT_W;
  localparam int BITCNT_W  = 6;   // holds VALUE_W itself
  localparam int DIGCNT_W  = 4;   // holds NUM_DIGITS itself

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;

  // status from the binary to BCD converter
  typedef struct packed {
    logic busy;
    logic done;
  } dabble_status_t;

endpackage

// ===== rtl/sitd_in_if.sv =====
`timescale 1ns / 1ps

interface sitd_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== rtl/sitd_out_if.sv =====
`timescale 1ns / 1ps

interface sitd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== rtl/signed_int_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
// Steps per request: accept, 32 BCD shift steps in the bit-serial double dabble, a
// handoff, then one step per digit position plus one for '-'; leading zeros are skipped
// and each character can wait on dout.ready. A new request is accepted only in idle,
// after the last digit of the previous one has been registered for output.
// Reset: synchronous active-high rst clears state and output valid.
module signed_int_to_decimal_ascii (
  input  logic       clk,
  input  logic       rst,
  sitd_in_if.sink    din,
  sitd_out_if.source dout
);
  import sitd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t               state;
  logic                 accept;
  logic [VALUE_W-1:0]   mag;
  logic [BCD_W-1:0]     bcd_conv;
  dabble_status_t       dab_status;

  logic [BCD_W-1:0]     digits;
  logic [DIGCNT_W-1:0]  left;
  logic                 seen;
  logic                 minus_pend;
  logic                 out_valid;
  logic [CHAR_W-1:0]    out_char;
  logic                 out_last;

  logic [DIGIT_W-1:0]   top_digit;
  logic                 slot_free;
  logic                 skip;
  logic                 emit;

  assign accept = din.valid && din.ready;
  assign din.ready = (state == ST_IDLE);
  assign mag = din.value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(din.value))
                                    : VALUE_W'(din.value);

  sitd_dabble u_dabble (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .mag    (mag),
    .bcd    (bcd_conv),
    .status (dab_status)
  );

  assign top_digit = digits[BCD_W-1 -: DIGIT_W];
  assign slot_free = !out_valid || dout.ready;
  // leading zeros are dropped, but the units digit always goes out
  assign skip = (top_digit == '0) && !seen && (left != DIGCNT_W'(1));
  assign emit = (state == ST_EMIT) && slot_free && (minus_pend || !skip);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      minus_pend <= 1'b0;
      seen       <= 1'b0;
      left       <= '0;
    end else begin
      if (out_valid && dout.ready && !emit) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            minus_pend <= din.value[VALUE_W-1];
            state      <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (dab_status.done && !dab_status.busy) begin
            left  <= DIGCNT_W'(NUM_DIGITS);
            seen  <= 1'b0;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (minus_pend) begin
            if (slot_free) begin
              out_valid  <= 1'b1;
              minus_pend <= 1'b0;
            end
          end else if (skip) begin
            left <= left - 1'b1;
          end else if (slot_free) begin
            out_valid <= 1'b1;
            seen      <= 1'b1;
            left      <= left - 1'b1;
            if (left == DIGCNT_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CONV && dab_status.done) begin
      digits <= bcd_conv;
    end else if (state == ST_EMIT && !minus_pend && (skip || slot_free)) begin
      digits <= {digits[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
    if (state == ST_EMIT && slot_free) begin
      if (minus_pend) begin
        out_char <= CH_MINUS;
        out_last <= 1'b0;
      end else if (!skip) begin
        out_char <= CH_ZERO + CHAR_W'(top_digit);
        out_last <= (left == DIGCNT_W'(1));
      end
    end
  end

  assign dout.valid     = out_valid;
  assign dout.character = out_char;
  assign dout.last      = out_last;

endmodule

// ===== rtl/sitd_dabble.sv =====
`timescale 1ns / 1ps

// Bit-serial binary to BCD (shift and add-3), one magnitude bit per cycle.
module sitd_dabble (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [sitd_pkg::VALUE_W-1:0]        mag,
  output logic [sitd_pkg::BCD_W-1:0]          bcd,
  output sitd_pkg::dabble_status_t            status
);
  import sitd_pkg::*;

  logic [VALUE_W-1:0]  shreg;
  logic [BITCNT_W-1:0] count;
  logic                done;
  logic [BCD_W-1:0]    bcd_adj;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= BITCNT_W'(VALUE_W);
      end else if (count != '0) begin
        count <= count - 1'b1;
        done  <= (count == BITCNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= mag;
      bcd   <= '0;
    end else if (count != '0) begin
      shreg <= {shreg[VALUE_W-2:0], 1'b0};
      bcd   <= {bcd_adj[BCD_W-2:0], shreg[VALUE_W-1]};
    end
  end

  assign status.busy = (count != '0);
  assign status.done = done;

endmodule

// ===== tb/sv/signed_int_to_decimal_ascii_tb.sv =====
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_tb;
  import sitd_pkg::*;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  class decimal_text_board;
    text_char_t pending_chars[$];
    int         mismatches;
    int         chars_seen;

    function new();
      mismatches = 0;
      chars_seen = 0;
    endfunction

    task report(input string msg);
      mismatches++;
      $display("ERROR: %s", msg);
    endtask

    // decimal text of one request, most significant character first
    function void note_value(input logic signed [VALUE_W-1:0] value);
      logic [VALUE_W-1:0]  raw;
      logic [VALUE_W-1:0]  mag;
      logic [DIGIT_W-1:0]  digits[NUM_DIGITS];
      int                  nd;
      text_char_t          c;
      raw = value;
      // magnitude as unsigned, so the most negative value gives 2147483648
      mag = raw[VALUE_W-1] ? (32'd0 - raw) : raw;
      nd = 0;
      do begin
        digits[nd] = DIGIT_W'(mag % 10);
        nd++;
        mag = mag / 10;
      end while (mag != 0 && nd < NUM_DIGITS);
      if (raw[VALUE_W-1]) begin
        c.ch = CH_MINUS;
        c.last = 1'b0;
        pending_chars.push_back(c);
      end
      for (int k = nd - 1; k >= 0; k--) begin
        c.ch = CH_ZERO + digits[k];
        c.last = (k == 0);
        pending_chars.push_back(c);
      end
    endfunction

    task check_char(input logic [CHAR_W-1:0] ch, input logic last);
      text_char_t want;
      chars_seen++;
      if (pending_chars.size() == 0) begin
        report($sformatf("char %0d: unexpected 0x%02h last=%0b", chars_seen, ch, last));
        return;
      end
      want = pending_chars.pop_front();
      if (ch !== want.ch)
        report($sformatf("char %0d: character 0x%02h, want 0x%02h", chars_seen, ch, want.ch));
      if (last !== want.last)
        report($sformatf("char %0d: last %0b, want %0b", chars_seen, last, want.last));
    endtask
  endclass

  localparam int RANDOM_ITEMS = 312;
  localparam int DRAIN_LIMIT  = 5000;

  logic clk;
  logic rst;

  sitd_in_if  in_if ();
  sitd_out_if out_if ();

  decimal_text_board board = new();

  logic signed [VALUE_W-1:0] stim_values[$];
  int                        n_directed;

  signed_int_to_decimal_ascii dut (
    .clk  (clk),
    .rst  (rst),
    .din  (in_if),
    .dout (out_if)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_if.valid && out_if.ready)
      board.check_char(out_if.character, out_if.last);
  end

  function automatic longint pow10(input int d);
    longint p;
    p = 1;
    repeat (d) p = p * 10;
    return p;
  endfunction

  function automatic logic [VALUE_W-1:0] signed_from_mag(input longint m);
    logic [VALUE_W-1:0] v;
    v = m[VALUE_W-1:0];
    // 2147483648 only exists as a negative value
    if (m == 64'd2147483648 || ($urandom_range(0, 1) == 1 && m != 0))
      v = 32'd0 - v;
    return v;
  endfunction

  // mix of raw bit patterns, every digit count and values around powers of ten
  function automatic logic [VALUE_W-1:0] random_value();
    int     sel;
    int     d;
    longint lo;
    longint hi;
    longint m;
    sel = $urandom_range(0, 9);
    if (sel < 3) return $urandom();
    if (sel < 8) begin
      d = $urandom_range(1, NUM_DIGITS);
      lo = (d == 1) ? 0 : pow10(d - 1);
      hi = pow10(d) - 1;
      m = lo + ({$urandom(), $urandom()} & 64'h7fff_ffff_ffff_ffff) % (hi - lo + 1);
      if (m > 64'd2147483648) m = lo + (m % (64'd2147483649 - lo));
      return signed_from_mag(m);
    end
    d = $urandom_range(1, NUM_DIGITS - 1);
    m = pow10(d) + $urandom_range(0, 2) - 1;
    return signed_from_mag(m);
  endfunction

  task automatic send_value(input logic signed [VALUE_W-1:0] v);
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.value <= v;
    do @(posedge clk); while (!in_if.ready);
    board.note_value(v);
  endtask

  task automatic idle_gap(input int n);
    @(negedge clk);
    in_if.valid <= 1'b0;
    in_if.value <= $urandom();
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic pause_until_drained();
    idle_gap(1);
    while (board.pending_chars.size() != 0) @(posedge clk);
  endtask

  // receiver: spans of always-ready, light stalls and heavy stalls
  initial begin
    int mode;
    int span;
    out_if.ready = 1'b0;
    @(negedge rst);
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(8, 80);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= ($urandom_range(0, 3) != 0);
          default: out_if.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  initial begin
    int idx;
    int burst;
    int gap;
    int wait_cnt;
    rst = 1'b1;
    in_if.valid = 1'b0;
    in_if.value = '0;

    stim_values = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd7, 32'sd10, -32'sd10,
                    32'sd99, 32'sd100, -32'sd999, 32'sd12345678, 32'sd999999999,
                    32'sd1000000000, -32'sd1000000000, 32'sd2147483647,
                    -32'sd2147483647, 32'sh8000_0000, 32'sh5555_5555,
                    32'shAAAA_AAAA};
    n_directed = stim_values.size();
    repeat (RANDOM_ITEMS) stim_values.push_back(random_value());

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    idx = 0;
    while (idx < stim_values.size()) begin
      burst = $urandom_range(1, 10);
      for (int j = 0; j < burst && idx < stim_values.size(); j++) begin
        send_value(stim_values[idx]);
        idx++;
        // hold requests back until the output side has caught up
        if (idx == n_directed || idx % 110 == 0) pause_until_drained();
      end
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
      if (gap > 0) idle_gap(gap);
    end
    idle_gap(1);

    wait_cnt = 0;
    while (board.pending_chars.size() != 0 && wait_cnt < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cnt++;
    end
    if (board.pending_chars.size() != 0)
      board.report($sformatf("%0d characters never arrived", board.pending_chars.size()));
    repeat (60) @(posedge clk);

    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sitd_pkg.sv
rtl/sitd_in_if.sv
rtl/sitd_out_if.sv
rtl/sitd_dabble.sv
rtl/signed_int_to_decimal_ascii.sv
tb/sv/signed_int_to_decimal_ascii_tb.sv
